@@ design/percolation_spanning_test_assert.svh @@
// Assertion macros used by percolation_spanning_test.sv.
`ifndef PERCOLATION_SPANNING_TEST_ASSERT_SVH
`define PERCOLATION_SPANNING_TEST_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define PST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define PST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ design/pst_pkg.sv @@
`timescale 1ns / 1ps
package pst_pkg;
    localparam logic [1:0] SITE_BLANK   = 2'd0;
    localparam logic [1:0] SITE_FILLED  = 2'd1;
    localparam logic [1:0] SITE_BLOCKED = 2'd2;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_FILL  = 2'd1;
    localparam logic [1:0] CMD_BLOCK = 2'd2;
    localparam logic [1:0] CMD_NONE  = 2'd3;

    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;

    // Moves by direction index modulo four: up, left, down, right.
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_DOWN  = 2'd2;
    localparam logic [1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic taken;
        logic spanning;
    } t_result;
endpackage

@@ design/pst_ram.sv @@
`timescale 1ns / 1ps
module pst_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ design/percolation_spanning_test.sv @@
`timescale 1ns / 1ps
// Channel  | Direction | Handshake           | Payload
// input    | in        | i_valid / o_ready   | i_cmd, i_site_row, i_site_col
// result   | out       | o_valid / i_ready   | o_taken, o_spanning, o_filled_total
// config   | in        | APB psel/penable    | row_count (0x0), column_count (0x4)
//
// A clear, block or refused fill passes through the read and check states to the
// output, plus a clearing pass for a clear. A fill running the spanning walk passes
// the scan states per top-row column scanned and a probe and check state per walk
// probe, up to four probes per move; its length follows the walk via the RAM port.
// After reset and after every clear or configuration write, a clearing pass writes
// one grid RAM entry per cycle to sweep the grid while o_ready stays low.
// The result is held in an output register; o_ready stays low until it is taken.
module percolation_spanning_test #(
    parameter int MAX_ROWS = 64,
    parameter int MAX_COLS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [6:0]  i_site_row,
    input  logic [6:0]  i_site_col,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_taken,
    output logic        o_spanning,
    output logic [12:0] o_filled_total
);
    import pst_pkg::*;

    localparam int RB = $clog2(MAX_ROWS);
    localparam int CB = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
    localparam int AB = RB + CB;
    localparam int DEPTH = 1 << AB;
    localparam int LB = AB + 3;                  // walk budget width
    localparam logic [LB-1:0] WALK_LIMIT = LB'(4 * MAX_ROWS * MAX_COLS);
    localparam logic [6:0] MAXR7 = 7'(MAX_ROWS > 127 ? 127 : MAX_ROWS);
    localparam logic [6:0] MAXC7 = 7'(MAX_COLS > 127 ? 127 : MAX_COLS);

    // Walk coordinates carry one spare bit and one extra for stepping off the area.
    typedef enum logic [10:0] {
        S_CLEAR  = 11'b00000000001,
        S_IDLE   = 11'b00000000010,
        S_RD     = 11'b00000000100,
        S_CHK    = 11'b00000001000,
        S_ROWS   = 11'b00000010000,
        S_SCAN   = 11'b00000100000,
        S_SCHK   = 11'b00001000000,
        S_PROBE  = 11'b00010000000,
        S_PCHK   = 11'b00100000000,
        S_OUT    = 11'b01000000000,
        S_SCHK2  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;
    logic [6:0] r_rows, r_cols;
    logic [AB-1:0] r_clr;
    logic [1:0] r_cmd;
    logic [6:0] r_srow, r_scol;
    logic [12:0] r_total;
    logic [MAX_ROWS-1:0] r_rowhas;
    logic [7:0] r_wr, r_wc;            // walk position, one-based
    logic [2:0] r_t;                   // probe index 0..3 within a move
    logic [1:0] r_dir;                 // dir modulo 4 of last move
    logic [LB-1:0] r_budget;
    t_result r_res;
    logic r_ovalid;

    // Grid RAM with one shared read port used by every probe.
    logic          ram_we;
    logic [AB-1:0] ram_waddr, ram_raddr;
    logic [1:0]    ram_wdata, ram_rdata;

    pst_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_grid (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    function automatic logic [AB-1:0] addr_of(logic [7:0] r, logic [7:0] c);
        logic [RB-1:0] rr;
        logic [CB-1:0] cc;
        rr = RB'(r - 8'd1);
        cc = CB'(c - 8'd1);
        return {rr, cc};
    endfunction

    // Direction of current probe: (base-1+t) mod 4, base-1 = (dir+3) mod 4.
    logic [1:0] probe_dir;
    logic [7:0] pr, pc;
    logic       p_in;
    assign probe_dir = 2'(r_dir + 2'd3 + 2'(r_t));
    always_comb begin
        pr = r_wr;
        pc = r_wc;
        case (probe_dir)
            DIR_UP:    pr = r_wr - 8'd1;
            DIR_LEFT:  pc = r_wc - 8'd1;
            DIR_DOWN:  pr = r_wr + 8'd1;
            DIR_RIGHT: pc = r_wc + 8'd1;
            default:   pr = r_wr;
        endcase
    end
    assign p_in = (pr >= 8'd1) && (pr <= {1'b0, r_rows}) &&
                  (pc >= 8'd1) && (pc <= {1'b0, r_cols});

    logic in_ok, all_rows;
    assign in_ok = (r_srow >= 7'd1) && (r_srow <= r_rows) &&
                   (r_scol >= 7'd1) && (r_scol <= r_cols);
    always_comb begin
        all_rows = 1'b1;
        for (int i = 0; i < MAX_ROWS; i++) begin
            if (i < int'(r_rows) && !r_rowhas[i]) all_rows = 1'b0;
        end
    end

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_COLS) prdata[6:0] = r_cols;
        else                      prdata[6:0] = r_rows;
    end

    logic [6:0] wv;
    assign wv = pwdata[6:0];

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_of({1'b0, r_srow}, {1'b0, r_scol});
        ram_wdata = (r_cmd == CMD_BLOCK) ? SITE_BLOCKED : SITE_FILLED;
        ram_raddr = addr_of({1'b0, r_srow}, {1'b0, r_scol});
        n_state   = r_state;
        case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = SITE_BLANK;
                if (&r_clr) n_state = S_IDLE;
            end
            S_IDLE:  if (i_valid) n_state = S_RD;
            S_RD:    n_state = S_CHK;
            S_CHK: begin
                if (r_cmd == CMD_CLEAR) n_state = S_OUT;
                else if ((r_cmd == CMD_FILL || r_cmd == CMD_BLOCK) && in_ok &&
                         ram_rdata == SITE_BLANK) begin
                    ram_we = 1'b1;
                    n_state = (r_cmd == CMD_FILL) ? S_ROWS : S_OUT;
                end else n_state = S_OUT;
            end
            S_ROWS:  n_state = all_rows ? S_SCAN : S_OUT;
            S_SCAN: begin
                ram_raddr = addr_of(8'd1, r_wc);
                n_state = (r_wc > {1'b0, r_cols}) ? S_OUT : S_SCHK;
            end
            S_SCHK: begin
                ram_raddr = addr_of(8'd2, r_wc);
                n_state = (ram_rdata == SITE_FILLED) ? S_SCHK2 : S_SCAN;
            end
            S_SCHK2: n_state = (ram_rdata == SITE_FILLED) ? S_PROBE : S_SCAN;
            S_PROBE: begin
                ram_raddr = addr_of(pr, pc);
                if (r_t == 3'd0 && r_budget == '0) n_state = S_OUT;
                else n_state = S_PCHK;
            end
            S_PCHK: begin
                if ((p_in && ram_rdata == SITE_FILLED) || r_t == 3'd3) begin
                    if (p_in && ram_rdata == SITE_FILLED && pr == {1'b0, r_rows})
                        n_state = S_OUT;
                    else if (p_in && ram_rdata == SITE_FILLED && pr == 8'd1)
                        n_state = S_SCAN;
                    else n_state = S_PROBE;
                end else n_state = S_PROBE;
            end
            S_OUT: begin
                if (i_ready) n_state = (r_cmd == CMD_CLEAR) ? S_CLEAR : S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
        if (cfg_wr) n_state = S_CLEAR;
    end

    logic p_hit;
    assign p_hit = p_in && ram_rdata == SITE_FILLED;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_rows   <= 7'd10;
            r_cols   <= 7'd10;
            r_clr    <= '0;
            r_total  <= '0;
            r_rowhas <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= AB'(r_clr + 1'b1);
            case (r_state)
                S_IDLE: if (i_valid) begin
                    r_cmd  <= i_cmd;
                    r_srow <= i_site_row;
                    r_scol <= i_site_col;
                    r_res  <= '0;
                end
                S_CHK: begin
                    if (r_cmd == CMD_CLEAR) begin
                        r_total  <= '0;
                        r_rowhas <= '0;
                    end else if (ram_we) begin
                        r_res.taken <= 1'b1;
                        if (r_cmd == CMD_FILL) begin
                            r_total <= 13'(r_total + 13'd1);
                            r_rowhas[RB'(r_srow - 7'd1)] <= 1'b1;
                        end
                    end
                    r_wc     <= 8'd1;
                    r_budget <= WALK_LIMIT;
                end
                S_SCHK2: if (ram_rdata == SITE_FILLED) begin
                    r_wr  <= 8'd2;
                    r_dir <= DIR_DOWN;
                    r_t   <= 3'd0;
                end else r_wc <= 8'(r_wc + 8'd1);
                S_SCHK:  if (ram_rdata != SITE_FILLED) r_wc <= 8'(r_wc + 8'd1);
                S_PROBE: if (r_t == 3'd0) r_budget <= LB'(r_budget - 1'b1);
                S_PCHK: begin
                    if (p_hit || r_t == 3'd3) begin
                        // With no neighbor found the next search starts one turn on.
                        r_dir <= p_hit ? probe_dir : 2'(r_dir + 2'd3);
                        r_t   <= 3'd0;
                        if (p_hit) begin
                            r_wr <= pr;
                            r_wc <= pc;
                            if (pr == {1'b0, r_rows}) r_res.spanning <= 1'b1;
                            else if (pr == 8'd1) r_wc <= 8'(pc + 8'd1);
                        end
                    end else r_t <= 3'(r_t + 3'd1);
                end
                default: ;
            endcase
            if (r_state == S_OUT && i_ready) r_ovalid <= 1'b0;
            else if (n_state == S_OUT && r_state != S_OUT) r_ovalid <= 1'b1;
            if (cfg_wr) begin
                r_clr    <= '0;
                r_total  <= '0;
                r_rowhas <= '0;
                r_ovalid <= 1'b0;
                if (paddr[2] == REG_ROWS)
                    r_rows <= (wv < 7'd2) ? 7'd2 : (wv > MAXR7 ? MAXR7 : wv);
                else
                    r_cols <= (wv < 7'd1) ? 7'd1 : (wv > MAXC7 ? MAXC7 : wv);
            end
        end
    end

    // A clear item also sweeps the grid once its result has been taken.
    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_ovalid;
    assign o_taken        = r_res.taken;
    assign o_spanning     = r_res.spanning;
    assign o_filled_total = r_total;

    `include "percolation_spanning_test_assert.svh"
    `PST_ASSERT_IMP(a_valid_out, i_clk, i_rst_n, o_valid, r_state == S_OUT)
    `PST_ASSERT_IMP(a_span_taken, i_clk, i_rst_n, o_valid && o_spanning, o_taken)
    `PST_ASSERT_NXT(a_accept, i_clk, i_rst_n, i_valid && o_ready && !cfg_wr, r_state == S_RD)
endmodule

@@ tb/sv/percolation_spanning_test_test.sv @@
`timescale 1ns / 1ps
module percolation_spanning_test_test;
    import pst_pkg::*;

    // The run is stopped here if no verdict has been reached. A fill can walk
    // for a long time, so the limit leaves plenty of room.
    localparam int CYCLE_LIMIT = 200_000_000;
    localparam int GRID_MAX    = 64;
    localparam int MOVE_BUDGET = 4 * GRID_MAX * GRID_MAX;
    // A clear or a register write starts a clearing pass over the whole grid.
    localparam int SETTLE_CYCLES = 64;

    // Row and column steps for up, left, down, right, written out twice so
    // that the rotating search never has to wrap its index.
    localparam int STEP_DR [8] = '{-1, 0, 1, 0, -1, 0, 1, 0};
    localparam int STEP_DC [8] = '{0, -1, 0, 1, 0, -1, 0, 1};

    typedef struct packed {
        logic        taken;
        logic        spanning;
        logic [12:0] filled_total;
    } fill_outcome_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_cmd = CMD_CLEAR;
    logic [6:0]  i_site_row = '0;
    logic [6:0]  i_site_col = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_taken;
    logic        o_spanning;
    logic [12:0] o_filled_total;

    // Our own copy of the lattice and its counters.
    logic [1:0]    lattice [GRID_MAX][GRID_MAX];
    int            row_fills [GRID_MAX];
    int            filled_count;
    int            rows_in_use;
    int            cols_in_use;
    fill_outcome_t pending_outcomes [$];

    int  error_count = 0;
    int  cycle_count = 0;
    bit  steady_flow = 1'b0;

    percolation_spanning_test DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_site_row     (i_site_row),
        .i_site_col     (i_site_col),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_taken        (o_taken),
        .o_spanning     (o_spanning),
        .o_filled_total (o_filled_total)
    );

    always #5 i_clk = ~i_clk;

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // The receiver stalls about 13 percent of the time, except while the
    // steady-flow stretch is on.
    always @(negedge i_clk) begin
        i_ready <= steady_flow || ($urandom_range(99) >= 13);
    end

    function automatic void wipe_lattice();
        for (int r = 0; r < GRID_MAX; r++) begin
            row_fills[r] = 0;
            for (int c = 0; c < GRID_MAX; c++) lattice[r][c] = SITE_BLANK;
        end
        filled_count = 0;
    endfunction

    function automatic bit site_in_area(int r, int c);
        return r >= 1 && r <= rows_in_use && c >= 1 && c <= cols_in_use;
    endfunction

    function automatic bit site_is_filled(int r, int c);
        if (!site_in_area(r, c)) return 1'b0;
        return lattice[r-1][c-1] == SITE_FILLED;
    endfunction

    // Right-hand wall walk from the scanned top-row columns whose first two rows
    // are filled. Reaching the last row after a move means the cluster spans.
    function automatic bit cluster_spans();
        int budget;
        int c;
        int r;
        int heading;
        int base;
        int t;
        budget = MOVE_BUDGET;
        c = 1;
        while (c <= cols_in_use) begin
            if (site_is_filled(1, c) && site_is_filled(2, c)) begin
                r = 2;
                heading = 2;
                while (r > 1) begin
                    if (budget == 0) return 1'b0;
                    budget--;
                    base = heading % 4;
                    if (base == 0) base = 4;
                    for (t = base - 1; t < base + 3; t++) begin
                        if (site_is_filled(r + STEP_DR[t], c + STEP_DC[t])) begin
                            r = r + STEP_DR[t];
                            c = c + STEP_DC[t];
                            break;
                        end
                    end
                    heading = t;
                    if (r == rows_in_use) return 1'b1;
                end
            end
            c++;
        end
        return 1'b0;
    endfunction

    function automatic fill_outcome_t predict_outcome(logic [1:0] cmd, int r, int c);
        fill_outcome_t res;
        bit all_rows;
        res = '0;
        if (cmd == CMD_CLEAR) begin
            wipe_lattice();
        end else if ((cmd == CMD_FILL || cmd == CMD_BLOCK) && site_in_area(r, c)) begin
            if (lattice[r-1][c-1] == SITE_BLANK) begin
                res.taken = 1'b1;
                if (cmd == CMD_BLOCK) begin
                    lattice[r-1][c-1] = SITE_BLOCKED;
                end else begin
                    lattice[r-1][c-1] = SITE_FILLED;
                    row_fills[r-1]++;
                    filled_count++;
                    all_rows = 1'b1;
                    for (int k = 0; k < rows_in_use; k++)
                        if (row_fills[k] == 0) all_rows = 1'b0;
                    if (all_rows) res.spanning = cluster_spans();
                end
            end
        end
        res.filled_total = filled_count[12:0];
        return res;
    endfunction

    // Checks every result transaction against the oldest expectation.
    always @(posedge i_clk) begin
        fill_outcome_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result taken=%0b spanning=%0b total=%0d",
                         $time, o_taken, o_spanning, o_filled_total);
                error_count++;
            end else begin
                want = pending_outcomes.pop_front();
                if (o_taken !== want.taken) begin
                    $display("%0t: taken expected %0b actual %0b",
                             $time, want.taken, o_taken);
                    error_count++;
                end
                if (o_spanning !== want.spanning) begin
                    $display("%0t: spanning expected %0b actual %0b",
                             $time, want.spanning, o_spanning);
                    error_count++;
                end
                if (o_filled_total !== want.filled_total) begin
                    $display("%0t: filled_total expected %0d actual %0d",
                             $time, want.filled_total, o_filled_total);
                    error_count++;
                end
            end
        end
    end

    // Sends one transaction. Valid stays high from one call to the next
    // unless a random gap lowers it first.
    task automatic send_site(logic [1:0] cmd, int r, int c);
        @(negedge i_clk);
        if (!steady_flow && $urandom_range(99) < 13) begin
            i_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_cmd = cmd;
        i_site_row = r[6:0];
        i_site_col = c[6:0];
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        pending_outcomes.push_back(predict_outcome(cmd, r, c));
    endtask

    // Lowers valid and waits until every expected result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        i_valid = 1'b0;
        wait (pending_outcomes.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write of one register; the block must be idle. Any register write
    // also clears the lattice, and the values saturate into range.
    task automatic write_register(logic index, int value);
        int v;
        drain_results();
        wait (o_ready === 1'b1);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = {index, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        v = value & 127;
        if (index == REG_ROWS) rows_in_use = (v < 2) ? 2 : (v > GRID_MAX ? GRID_MAX : v);
        else cols_in_use = (v < 1) ? 1 : (v > GRID_MAX ? GRID_MAX : v);
        wipe_lattice();
    endtask

    task automatic set_lattice_size(int rows, int cols);
        write_register(REG_ROWS, rows);
        write_register(REG_COLS, cols);
    endtask

    // Default 10x10 lattice: extremes of the fields, every command, refused and
    // out-of-range sites, and a straight column that spans.
    task automatic test_directed_basics();
        send_site(CMD_FILL, 1, 1);
        send_site(CMD_FILL, 1, 1);
        send_site(CMD_BLOCK, 1, 1);
        send_site(CMD_BLOCK, 10, 10);
        send_site(CMD_FILL, 10, 10);
        send_site(CMD_FILL, 0, 5);
        send_site(CMD_FILL, 5, 0);
        send_site(CMD_BLOCK, 127, 127);
        send_site(CMD_FILL, 11, 3);
        send_site(CMD_FILL, 3, 11);
        send_site(CMD_NONE, 4, 4);
        for (int r = 2; r <= 10; r++) send_site(CMD_FILL, r, 1);
        send_site(CMD_CLEAR, 0, 0);
        send_site(CMD_FILL, 1, 1);
    endtask

    // Two rows and one column at the low extremes, then a wider two-row strip
    // where spanning needs a move along the second row.
    task automatic test_small_lattice();
        set_lattice_size(0, 0);
        send_site(CMD_FILL, 1, 1);
        send_site(CMD_FILL, 2, 1);
        send_site(CMD_FILL, 3, 1);
        set_lattice_size(2, 3);
        send_site(CMD_FILL, 1, 2);
        send_site(CMD_FILL, 2, 2);
        send_site(CMD_FILL, 2, 3);
        send_site(CMD_FILL, 2, 1);
    endtask

    // Largest lattice: corner sites, a site past the last row and a full right-edge column.
    task automatic test_large_lattice();
        set_lattice_size(127, 127);
        send_site(CMD_FILL, 64, 64);
        send_site(CMD_BLOCK, 64, 1);
        send_site(CMD_FILL, 65, 1);
        for (int r = 1; r <= 63; r++) send_site(CMD_FILL, r, 64);
    endtask

    // Random lattices: mostly fills of in-range sites with some blocks, a
    // few clears, wild coordinates and unknown commands as noise.
    task automatic test_random_fills(int rows, int cols, int count);
        int pick;
        set_lattice_size(rows, cols);
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                send_site(CMD_FILL, $urandom_range(1, rows_in_use),
                          $urandom_range(1, cols_in_use));
            else if (pick < 84)
                send_site(CMD_BLOCK, $urandom_range(1, rows_in_use),
                          $urandom_range(1, cols_in_use));
            else if (pick < 87)
                send_site(CMD_CLEAR, $urandom_range(127), $urandom_range(127));
            else if (pick < 96)
                send_site((pick < 92) ? CMD_FILL : CMD_BLOCK,
                          $urandom_range(127), $urandom_range(127));
            else
                send_site(CMD_NONE, $urandom_range(127), $urandom_range(127));
            // Once, the sender holds off until every result is back.
            if (n == count / 2) drain_results();
        end
    endtask

    initial begin
        rows_in_use = 10;
        cols_in_use = 10;
        wipe_lattice();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_basics();
        test_small_lattice();
        test_large_lattice();
        test_random_fills(6, 6, 70);
        steady_flow = 1'b1;
        test_random_fills(10, 10, 60);
        steady_flow = 1'b0;
        test_random_fills(3, 8, 50);
        test_random_fills(12, 5, 15);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+design
design/pst_pkg.sv
design/pst_ram.sv
design/percolation_spanning_test.sv
tb/sv/percolation_spanning_test_test.sv
